// ===== hw/rtl/srq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srq_pkg;

  // ring sizes
  localparam int SAMPLE_DEPTH = 65536;
  localparam int HEADER_DEPTH = 64;
  localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
  localparam int SAMPLE_CW    = SAMPLE_AW + 1;
  localparam int HDR_AW       = $clog2(HEADER_DEPTH);

  // field widths
  localparam int ACTION_W  = 3;
  localparam int CHAN_IN_W = 7;
  localparam int CH_W      = 2;
  localparam int FRAME_W   = 16;
  localparam int TIME_W    = 48;
  localparam int WORD_W    = 32;
  localparam int SHAPE_W   = CH_W + FRAME_W;
  localparam int NEED_W    = FRAME_W + 1;
  localparam int CMP_W     = (NEED_W > SAMPLE_CW) ? NEED_W : SAMPLE_CW;

  // channel count limit
  localparam int MAX_CHANNELS = 2;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // action codes on the input
  localparam logic [ACTION_W-1:0] ACT_PUSH_START = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRAME = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRAME  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TAKE_OVF   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH_START,
    OP_PUSH_FRAME,
    OP_POP_FRAME,
    OP_TAKE_OVF,
    OP_CLEAR,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_NO_ROOM = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE_RIGHT,
    S_POP_LEFT,
    S_POP_RIGHT,
    S_POP_END
  } state_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t                        op;
    logic                       bad_shape;
    logic [CH_W-1:0]            channels;
    logic [FRAME_W-1:0]         frames;
    logic [NEED_W-1:0]          needed;
    logic signed [TIME_W-1:0]   timeline;
    logic [WORD_W-1:0]          left;
    logic [WORD_W-1:0]          right;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srq_front (
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire logic [srq_pkg::ACTION_W-1:0]      action,
  input  wire logic [srq_pkg::CHAN_IN_W-1:0]     channel_count,
  input  wire logic [srq_pkg::FRAME_W-1:0]       frame_count,
  input  wire logic signed [srq_pkg::TIME_W-1:0] timeline_frame,
  input  wire logic [srq_pkg::WORD_W-1:0]        left_sample,
  input  wire logic [srq_pkg::WORD_W-1:0]        right_sample,
  output logic                                   cmd_valid,
  input  wire logic                              cmd_ready,
  output srq_pkg::cmd_t                          cmd
);

  logic [srq_pkg::CH_W-1:0] chan_clamped;

  // handshake goes straight to the queue
  assign cmd_valid  = item_valid;
  assign item_ready = cmd_ready;

  // clamp channel count to stereo
  assign chan_clamped = (channel_count > srq_pkg::CHAN_IN_W'(srq_pkg::MAX_CHANNELS)) ?
                        srq_pkg::CH_W'(srq_pkg::MAX_CHANNELS) :
                        channel_count[srq_pkg::CH_W-1:0];

  // decode action and precompute the sample room a block needs
  always_comb begin
    case (action)
      srq_pkg::ACT_PUSH_START: cmd.op = srq_pkg::OP_PUSH_START;
      srq_pkg::ACT_PUSH_FRAME: cmd.op = srq_pkg::OP_PUSH_FRAME;
      srq_pkg::ACT_POP_FRAME:  cmd.op = srq_pkg::OP_POP_FRAME;
      srq_pkg::ACT_TAKE_OVF:   cmd.op = srq_pkg::OP_TAKE_OVF;
      srq_pkg::ACT_CLEAR:      cmd.op = srq_pkg::OP_CLEAR;
      default:                 cmd.op = srq_pkg::OP_BAD;
    endcase
    cmd.bad_shape = (channel_count == '0) || (frame_count == '0);
    cmd.channels  = chan_clamped;
    cmd.frames    = frame_count;
    cmd.needed    = (chan_clamped == srq_pkg::CH_W'(srq_pkg::MAX_CHANNELS)) ?
                    {frame_count, 1'b0} : {1'b0, frame_count};
    cmd.timeline  = timeline_frame;
    cmd.left      = left_sample;
    cmd.right     = right_sample;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srq_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srq_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire srq_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output srq_pkg::cmd_t      pop_cmd
);

  srq_pkg::cmd_t                entries [srq_pkg::QUEUE_DEPTH];
  logic [srq_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [srq_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [srq_pkg::QUEUE_CW-1:0] count;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = (count != srq_pkg::QUEUE_CW'(srq_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == srq_pkg::QUEUE_AW'(srq_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == srq_pkg::QUEUE_AW'(srq_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srq_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire srq_pkg::cmd_t                 cmd,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic [1:0]                         status,
  output logic [srq_pkg::WORD_W-1:0]         out_left,
  output logic [srq_pkg::WORD_W-1:0]         out_right,
  output logic signed [srq_pkg::TIME_W-1:0]  block_timeline,
  output logic [srq_pkg::CH_W-1:0]           block_channels,
  output logic [srq_pkg::FRAME_W-1:0]        block_frames,
  output logic                               end_of_block,
  output logic                               overflow_seen
);

  // rings
  logic [srq_pkg::WORD_W-1:0]  sample_mem [srq_pkg::SAMPLE_DEPTH];
  logic [srq_pkg::TIME_W-1:0]  hdr_pos_mem [srq_pkg::HEADER_DEPTH];
  logic [srq_pkg::SHAPE_W-1:0] hdr_shape_mem [srq_pkg::HEADER_DEPTH];

  logic                          smp_we;
  logic [srq_pkg::SAMPLE_AW-1:0] smp_waddr;
  logic [srq_pkg::WORD_W-1:0]    smp_wdata;
  logic [srq_pkg::SAMPLE_AW-1:0] smp_raddr;
  logic [srq_pkg::WORD_W-1:0]    smp_rdata;
  logic                          hdr_we;
  logic [srq_pkg::TIME_W-1:0]    hdr_pos_rdata;
  logic [srq_pkg::SHAPE_W-1:0]   hdr_shape_rdata;
  logic [srq_pkg::CH_W-1:0]      rd_ch;
  logic [srq_pkg::FRAME_W-1:0]   rd_frames;

  // control state
  srq_pkg::state_t               state, state_next;
  logic [srq_pkg::HDR_AW-1:0]    hdr_wr_idx, hdr_wr_idx_next;
  logic [srq_pkg::HDR_AW-1:0]    hdr_rd_idx, hdr_rd_idx_next;
  logic [srq_pkg::SAMPLE_AW-1:0] smp_wr_idx, smp_wr_idx_next;
  logic [srq_pkg::SAMPLE_AW-1:0] smp_rd_idx, smp_rd_idx_next;
  logic [srq_pkg::SAMPLE_AW-1:0] push_pos, push_pos_next;
  logic [srq_pkg::SAMPLE_AW-1:0] pop_pos, pop_pos_next;
  logic                          overflow, overflow_next;
  logic                          open_blk, open_blk_next;
  logic [srq_pkg::CH_W-1:0]      open_ch, open_ch_next;
  logic [srq_pkg::FRAME_W-1:0]   frames_left, frames_left_next;
  logic [srq_pkg::FRAME_W-1:0]   pop_done, pop_done_next;

  // payload holding registers
  logic [srq_pkg::WORD_W-1:0]    cur_right, cur_right_next;
  logic [srq_pkg::WORD_W-1:0]    pop_left, pop_left_next;
  logic [srq_pkg::WORD_W-1:0]    pop_right, pop_right_next;
  logic [srq_pkg::TIME_W-1:0]    hdr_time, hdr_time_next;
  logic [srq_pkg::CH_W-1:0]      hdr_ch, hdr_ch_next;
  logic [srq_pkg::FRAME_W-1:0]   hdr_frames, hdr_frames_next;

  // result register
  logic                          res_valid;
  srq_pkg::status_t              res_status, ld_status;
  logic [srq_pkg::WORD_W-1:0]    res_left, ld_left;
  logic [srq_pkg::WORD_W-1:0]    res_right, ld_right;
  logic [srq_pkg::TIME_W-1:0]    res_time, ld_time;
  logic [srq_pkg::CH_W-1:0]      res_ch, ld_ch;
  logic [srq_pkg::FRAME_W-1:0]   res_frames, ld_frames;
  logic                          res_eob, ld_eob;
  logic                          res_ovf, ld_ovf;
  logic                          res_load;

  // helpers
  logic                          res_free;
  logic                          take;
  logic [srq_pkg::HDR_AW-1:0]    hdr_wr_inc;
  logic [srq_pkg::HDR_AW-1:0]    hdr_rd_inc;
  logic [srq_pkg::SAMPLE_AW-1:0] push_pos_inc;
  logic [srq_pkg::SAMPLE_AW-1:0] pop_pos_inc;
  logic [srq_pkg::SAMPLE_CW-1:0] smp_used;
  logic [srq_pkg::SAMPLE_CW-1:0] smp_free;
  logic                          hdr_full;
  logic                          hdr_empty;
  logic                          room_ok;
  logic                          last_push;
  logic [srq_pkg::FRAME_W-1:0]   pop_done_inc;
  logic                          pop_last;

  assign res_free  = !res_valid || result_ready;
  assign take      = (state == srq_pkg::S_IDLE) && cmd_valid && res_free;
  assign cmd_ready = take;

  assign hdr_wr_inc   = (hdr_wr_idx == srq_pkg::HDR_AW'(srq_pkg::HEADER_DEPTH - 1)) ?
                        '0 : hdr_wr_idx + 1'b1;
  assign hdr_rd_inc   = (hdr_rd_idx == srq_pkg::HDR_AW'(srq_pkg::HEADER_DEPTH - 1)) ?
                        '0 : hdr_rd_idx + 1'b1;
  assign push_pos_inc = (push_pos == srq_pkg::SAMPLE_AW'(srq_pkg::SAMPLE_DEPTH - 1)) ?
                        '0 : push_pos + 1'b1;
  assign pop_pos_inc  = (pop_pos == srq_pkg::SAMPLE_AW'(srq_pkg::SAMPLE_DEPTH - 1)) ?
                        '0 : pop_pos + 1'b1;

  // free sample slots, one kept spare
  assign smp_used = (smp_wr_idx >= smp_rd_idx) ?
                    ({1'b0, smp_wr_idx} - {1'b0, smp_rd_idx}) :
                    ({1'b0, smp_wr_idx} + srq_pkg::SAMPLE_CW'(srq_pkg::SAMPLE_DEPTH)
                     - {1'b0, smp_rd_idx});
  assign smp_free  = srq_pkg::SAMPLE_CW'(srq_pkg::SAMPLE_DEPTH - 1) - smp_used;
  assign room_ok   = srq_pkg::CMP_W'(cmd.needed) <= srq_pkg::CMP_W'(smp_free);
  assign hdr_full  = (hdr_wr_inc == hdr_rd_idx);
  assign hdr_empty = (hdr_wr_idx == hdr_rd_idx);
  assign last_push = (frames_left == srq_pkg::FRAME_W'(1));

  assign rd_ch        = hdr_shape_rdata[srq_pkg::SHAPE_W-1:srq_pkg::FRAME_W];
  assign rd_frames    = hdr_shape_rdata[srq_pkg::FRAME_W-1:0];
  assign pop_done_inc = pop_done + 1'b1;
  assign pop_last     = (pop_done_inc >= hdr_frames);

  // sample ring, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (smp_we) begin
      sample_mem[smp_waddr] <= smp_wdata;
    end
    smp_rdata <= sample_mem[smp_raddr];
  end

  // header rings, written at the write index and read at the read index
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_pos_mem[hdr_wr_idx]   <= cmd.timeline;
      hdr_shape_mem[hdr_wr_idx] <= {cmd.channels, cmd.frames};
    end
    hdr_pos_rdata   <= hdr_pos_mem[hdr_rd_idx];
    hdr_shape_rdata <= hdr_shape_mem[hdr_rd_idx];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srq_pkg::S_IDLE: begin
        if (take) begin
          case (cmd.op)
            srq_pkg::OP_PUSH_FRAME: begin
              if (open_blk && (open_ch > srq_pkg::CH_W'(1))) begin
                state_next = srq_pkg::S_WRITE_RIGHT;
              end
            end
            srq_pkg::OP_POP_FRAME: begin
              if (!hdr_empty) begin
                state_next = srq_pkg::S_POP_LEFT;
              end
            end
            default: state_next = srq_pkg::S_IDLE;
          endcase
        end
      end
      srq_pkg::S_WRITE_RIGHT: state_next = srq_pkg::S_IDLE;
      srq_pkg::S_POP_LEFT: begin
        state_next = (rd_ch > srq_pkg::CH_W'(1)) ? srq_pkg::S_POP_RIGHT : srq_pkg::S_POP_END;
      end
      srq_pkg::S_POP_RIGHT: state_next = srq_pkg::S_POP_END;
      srq_pkg::S_POP_END:   state_next = srq_pkg::S_IDLE;
      default:              state_next = srq_pkg::S_IDLE;
    endcase
  end

  // datapath, ring controls and result load
  always_comb begin
    hdr_wr_idx_next  = hdr_wr_idx;
    hdr_rd_idx_next  = hdr_rd_idx;
    smp_wr_idx_next  = smp_wr_idx;
    smp_rd_idx_next  = smp_rd_idx;
    push_pos_next    = push_pos;
    pop_pos_next     = pop_pos;
    overflow_next    = overflow;
    open_blk_next    = open_blk;
    open_ch_next     = open_ch;
    frames_left_next = frames_left;
    pop_done_next    = pop_done;
    cur_right_next   = cur_right;
    pop_left_next    = pop_left;
    pop_right_next   = pop_right;
    hdr_time_next    = hdr_time;
    hdr_ch_next      = hdr_ch;
    hdr_frames_next  = hdr_frames;
    smp_we           = 1'b0;
    smp_waddr        = push_pos;
    smp_wdata        = cmd.left;
    smp_raddr        = pop_pos;
    hdr_we           = 1'b0;
    res_load         = 1'b0;
    ld_status        = srq_pkg::STAT_OK;
    ld_left          = '0;
    ld_right         = '0;
    ld_time          = '0;
    ld_ch            = '0;
    ld_frames        = '0;
    ld_eob           = 1'b0;
    ld_ovf           = 1'b0;
    case (state)
      srq_pkg::S_IDLE: begin
        if (take) begin
          case (cmd.op)
            // reserve a header and sample room for a new block
            srq_pkg::OP_PUSH_START: begin
              res_load = 1'b1;
              if (cmd.bad_shape || open_blk) begin
                ld_status = srq_pkg::STAT_INVALID;
              end else if (hdr_full || !room_ok) begin
                ld_status     = srq_pkg::STAT_NO_ROOM;
                overflow_next = 1'b1;
              end else begin
                hdr_we           = 1'b1;
                open_blk_next    = 1'b1;
                open_ch_next     = cmd.channels;
                push_pos_next    = smp_wr_idx;
                frames_left_next = cmd.frames;
              end
            end
            // write left sample, right follows in its own cycle
            srq_pkg::OP_PUSH_FRAME: begin
              if (!open_blk) begin
                res_load  = 1'b1;
                ld_status = srq_pkg::STAT_EMPTY;
              end else begin
                smp_we        = 1'b1;
                push_pos_next = push_pos_inc;
                if (open_ch > srq_pkg::CH_W'(1)) begin
                  cur_right_next = cmd.right;
                end else begin
                  res_load         = 1'b1;
                  frames_left_next = frames_left - 1'b1;
                  if (last_push) begin
                    smp_wr_idx_next = push_pos_inc;
                    hdr_wr_idx_next = hdr_wr_inc;
                    open_blk_next   = 1'b0;
                  end
                end
              end
            end
            // read of the left sample and header starts here
            srq_pkg::OP_POP_FRAME: begin
              if (hdr_empty) begin
                res_load  = 1'b1;
                ld_status = srq_pkg::STAT_EMPTY;
              end
            end
            srq_pkg::OP_TAKE_OVF: begin
              res_load      = 1'b1;
              ld_ovf        = overflow;
              overflow_next = 1'b0;
            end
            // drop all published blocks and clear the overflow flag, an open block stays
            srq_pkg::OP_CLEAR: begin
              res_load        = 1'b1;
              hdr_rd_idx_next = hdr_wr_idx;
              smp_rd_idx_next = smp_wr_idx;
              pop_pos_next    = smp_wr_idx;
              pop_done_next   = '0;
              overflow_next   = 1'b0;
            end
            default: begin
              res_load  = 1'b1;
              ld_status = srq_pkg::STAT_INVALID;
            end
          endcase
        end
      end
      // second sample of a stereo frame, publish after the last frame
      srq_pkg::S_WRITE_RIGHT: begin
        smp_we           = 1'b1;
        smp_wdata        = cur_right;
        push_pos_next    = push_pos_inc;
        res_load         = 1'b1;
        frames_left_next = frames_left - 1'b1;
        if (last_push) begin
          smp_wr_idx_next = push_pos_inc;
          hdr_wr_idx_next = hdr_wr_inc;
          open_blk_next   = 1'b0;
        end
      end
      // capture left sample and header, start right read
      srq_pkg::S_POP_LEFT: begin
        pop_left_next   = smp_rdata;
        pop_right_next  = '0;
        hdr_time_next   = hdr_pos_rdata;
        hdr_ch_next     = rd_ch;
        hdr_frames_next = rd_frames;
        pop_pos_next    = pop_pos_inc;
        smp_raddr       = pop_pos_inc;
      end
      srq_pkg::S_POP_RIGHT: begin
        pop_right_next = smp_rdata;
        pop_pos_next   = pop_pos_inc;
      end
      // hand out the frame, free the block after its last frame
      srq_pkg::S_POP_END: begin
        res_load  = 1'b1;
        ld_left   = pop_left;
        ld_right  = pop_right;
        ld_time   = hdr_time;
        ld_ch     = hdr_ch;
        ld_frames = hdr_frames;
        ld_eob    = pop_last;
        if (pop_last) begin
          smp_rd_idx_next = pop_pos;
          hdr_rd_idx_next = hdr_rd_inc;
          pop_done_next   = '0;
        end else begin
          pop_done_next = pop_done_inc;
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= srq_pkg::S_IDLE;
      hdr_wr_idx  <= '0;
      hdr_rd_idx  <= '0;
      smp_wr_idx  <= '0;
      smp_rd_idx  <= '0;
      push_pos    <= '0;
      pop_pos     <= '0;
      overflow    <= 1'b0;
      open_blk    <= 1'b0;
      open_ch     <= '0;
      frames_left <= '0;
      pop_done    <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      hdr_wr_idx  <= hdr_wr_idx_next;
      hdr_rd_idx  <= hdr_rd_idx_next;
      smp_wr_idx  <= smp_wr_idx_next;
      smp_rd_idx  <= smp_rd_idx_next;
      push_pos    <= push_pos_next;
      pop_pos     <= pop_pos_next;
      overflow    <= overflow_next;
      open_blk    <= open_blk_next;
      open_ch     <= open_ch_next;
      frames_left <= frames_left_next;
      pop_done    <= pop_done_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_right  <= cur_right_next;
    pop_left   <= pop_left_next;
    pop_right  <= pop_right_next;
    hdr_time   <= hdr_time_next;
    hdr_ch     <= hdr_ch_next;
    hdr_frames <= hdr_frames_next;
    if (res_load) begin
      res_status <= ld_status;
      res_left   <= ld_left;
      res_right  <= ld_right;
      res_time   <= ld_time;
      res_ch     <= ld_ch;
      res_frames <= ld_frames;
      res_eob    <= ld_eob;
      res_ovf    <= ld_ovf;
    end
  end

  assign result_valid   = res_valid;
  assign status         = res_status;
  assign out_left       = res_left;
  assign out_right      = res_right;
  assign block_timeline = res_time;
  assign block_channels = res_ch;
  assign block_frames   = res_frames;
  assign end_of_block   = res_eob;
  assign overflow_seen  = res_ovf;

  // an open block always holds a reserved header slot
  a_open_hdr_reserved: assert property (@(posedge clk) disable iff (rst)
    open_blk |-> (hdr_wr_inc != hdr_rd_idx))
    else $error("open block lost its header reservation");

  // an open block is mono or stereo
  a_open_ch_range: assert property (@(posedge clk) disable iff (rst)
    open_blk |-> (open_ch == 2'd1 || open_ch == 2'd2))
    else $error("open block has bad channel count");

  // multi-cycle work never runs with a result still pending
  a_busy_res_free: assert property (@(posedge clk) disable iff (rst)
    (state != srq_pkg::S_IDLE) |-> !res_valid)
    else $error("result register busy during multi-cycle command");

  // a pop only proceeds with a published block
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == srq_pkg::S_POP_LEFT) |-> (hdr_rd_idx != hdr_wr_idx))
    else $error("pop started on empty header ring");

  // clear leaves no published block behind
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (take && cmd.op == srq_pkg::OP_CLEAR) |=> (hdr_rd_idx == hdr_wr_idx && pop_done == '0))
    else $error("clear left published blocks");

endmodule

`default_nettype wire

// ===== hw/rtl/sample_block_ring_queue.sv =====
// Results: the result register loads when the back end takes a push start, mono push frame,
// take overflow, clear or refused item from the queue; a stereo push frame loads it in
// S_WRITE_RIGHT and a pop in S_POP_END, after S_POP_LEFT and, for stereo, S_POP_RIGHT.
// Throughput: 1 item per cycle for control items while result_ready is high; stereo push frames
// and pops hold off the next item, set by the one write and one registered read port of the ring.
// A two-entry command queue takes input while the back end works or a result waits.
// Reset (rst, synchronous) clears indexes, flags and queues; ring contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module sample_block_ring_queue (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire logic [srq_pkg::ACTION_W-1:0]      action,
  input  wire logic [srq_pkg::CHAN_IN_W-1:0]     channel_count,
  input  wire logic [srq_pkg::FRAME_W-1:0]       frame_count,
  input  wire logic signed [srq_pkg::TIME_W-1:0] timeline_frame,
  input  wire logic [srq_pkg::WORD_W-1:0]        left_sample,
  input  wire logic [srq_pkg::WORD_W-1:0]        right_sample,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output logic [1:0]                             status,
  output logic [srq_pkg::WORD_W-1:0]             out_left,
  output logic [srq_pkg::WORD_W-1:0]             out_right,
  output logic signed [srq_pkg::TIME_W-1:0]      block_timeline,
  output logic [srq_pkg::CH_W-1:0]               block_channels,
  output logic [srq_pkg::FRAME_W-1:0]            block_frames,
  output logic                                   end_of_block,
  output logic                                   overflow_seen
);

  logic          fq_valid;
  logic          fq_ready;
  srq_pkg::cmd_t fq_cmd;
  logic          qb_valid;
  logic          qb_ready;
  srq_pkg::cmd_t qb_cmd;

  // decode and classify incoming items
  srq_front u_front (
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .action         (action),
    .channel_count  (channel_count),
    .frame_count    (frame_count),
    .timeline_frame (timeline_frame),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .cmd_valid      (fq_valid),
    .cmd_ready      (fq_ready),
    .cmd            (fq_cmd)
  );

  // short queue between front and back
  srq_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  // ring storage and command execution
  srq_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (qb_valid),
    .cmd_ready      (qb_ready),
    .cmd            (qb_cmd),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .status         (status),
    .out_left       (out_left),
    .out_right      (out_right),
    .block_timeline (block_timeline),
    .block_channels (block_channels),
    .block_frames   (block_frames),
    .end_of_block   (end_of_block),
    .overflow_seen  (overflow_seen)
  );

endmodule

`default_nettype wire
